@@ sv/signed_int_to_decimal_ascii_assert.svh @@
// Assertion macros for the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS
`define SITOA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sitoa assertion failed");
`define SITOA_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("sitoa forbidden condition");
`else
`define SITOA_ASSERT(lbl, clk, rst, prop)
`define SITOA_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ sv/sitoa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

  localparam int MAG_W  = 32;
  localparam int POS_W  = 4;
  localparam int CHAR_W = 8;
  localparam int DIG_W  = 4;
  localparam int SHF_W  = 2;
  // two guard bits: eight times the largest power of ten exceeds 32 bits
  localparam int TRY_W  = MAG_W + 2;

  localparam logic [POS_W-1:0]  POS_TOP     = 4'd9;
  localparam logic [SHF_W-1:0]  SHIFT_TOP   = 2'd3;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [MAG_W-1:0]  mag;
    logic [POS_W-1:0]  pos;
    logic [SHF_W-1:0]  shift;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic working;
  } seq_status_t;

  function automatic logic [MAG_W-1:0] pow10(input logic [POS_W-1:0] p);
    logic [MAG_W-1:0] r;
    case (p)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/sitoa_digit_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sitoa_digit_unit (
  input  wire logic                       clk,
  input  wire sitoa_pkg::unit_cmd_t       cmd,
  output logic [sitoa_pkg::DIG_W-1:0]     digit
);
  import sitoa_pkg::*;

  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] rem_next;
  logic [TRY_W-1:0] trial;
  logic [TRY_W-1:0] diff;
  logic             ge;

  // one compare-subtract of the power of ten scaled by 8, 4, 2 or 1
  always_comb begin
    trial    = {2'b00, pow10(cmd.pos)} << cmd.shift;
    diff     = {2'b00, rem} - trial;
    ge       = ~diff[TRY_W-1];
    rem_next = ge ? diff[MAG_W-1:0] : rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= cmd.mag;
    end else if (cmd.step) begin
      rem   <= rem_next;
      digit <= {digit[DIG_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ sv/sitoa_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sitoa_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [sitoa_pkg::MAG_W-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [sitoa_pkg::CHAR_W-1:0]       m_tdata,
  output logic                               m_tlast,
  output sitoa_pkg::unit_cmd_t               cmd,
  input  wire logic [sitoa_pkg::DIG_W-1:0]   digit,
  output sitoa_pkg::seq_status_t             status
);
  import sitoa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SIGN = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state;
  logic [POS_W-1:0] pos;
  logic [SHF_W-1:0] shift;
  logic             started;
  logic             slot_free;
  logic             skip_zero;
  logic             out_load;
  logic [MAG_W-1:0] mag;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign mag       = s_tdata[MAG_W-1] ? (~s_tdata + {{(MAG_W-1){1'b0}}, 1'b1}) : s_tdata;
  // drop leading zeros, but always show the units digit
  assign skip_zero = (digit == '0) && !started && (pos != '0);
  assign out_load  = slot_free &&
                     ((state == ST_SIGN) || ((state == ST_EMIT) && !skip_zero));

  always_comb begin
    cmd.load  = s_tready && s_tvalid;
    cmd.step  = (state == ST_STEP);
    cmd.mag   = mag;
    cmd.pos   = pos;
    cmd.shift = shift;
    status.busy    = (state != ST_IDLE);
    status.working = (state == ST_STEP) || (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      pos      <= POS_TOP;
      shift    <= SHIFT_TOP;
      started  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pos     <= POS_TOP;
            shift   <= SHIFT_TOP;
            started <= 1'b0;
            state   <= s_tdata[MAG_W-1] ? ST_SIGN : ST_STEP;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            m_tdata  <= ASCII_MINUS;
            m_tlast  <= 1'b0;
            state    <= ST_STEP;
          end
        end
        ST_STEP: begin
          shift <= shift - 2'd1;
          if (shift == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip_zero) begin
            pos   <= pos - 4'd1;
            shift <= SHIFT_TOP;
            state <= ST_STEP;
          end else if (slot_free) begin
            m_tdata  <= ASCII_ZERO + {4'd0, digit};
            m_tlast  <= (pos == '0);
            started  <= 1'b1;
            if (pos == '0) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos - 4'd1;
              shift <= SHIFT_TOP;
              state <= ST_STEP;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/signed_int_to_decimal_ascii.sv @@
// Converts one signed 32-bit integer per request into its decimal ASCII text,
// sent one character per output beat, most significant first, with a leading
// '-' for negatives and tlast on the final character. A single compare-subtract
// unit extracts each of the ten decimal positions by subtracting 8, 4, 2 and 1
// times the power of ten in turn, so a request keeps the block busy through the
// digit extraction, the emit or leading-zero skip of each decimal position, the
// minus sign for a negative, and any output stall. The input is accepted only
// when the previous request's last character has been loaded into the output
// register.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] character
  output logic             m_tlast
);
  import sitoa_pkg::*;

  unit_cmd_t         cmd;
  logic [DIG_W-1:0]  digit;
  seq_status_t       status;
  logic              char_ok;

  sitoa_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .digit    (digit),
    .status   (status)
  );

  sitoa_digit_unit u_unit (
    .clk   (clk),
    .cmd   (cmd),
    .digit (digit)
  );

  assign char_ok = (m_tdata == ASCII_MINUS) ||
                   ((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_NINE));

  `SITOA_ASSERT(a_busy_after_request, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  `SITOA_NEVER(a_minus_not_last, clk, rst, m_tvalid && m_tlast && (m_tdata == ASCII_MINUS))
  `SITOA_NEVER(a_ready_while_working, clk, rst, s_tready && status.working)
  `SITOA_NEVER(a_ready_while_busy, clk, rst, s_tready && status.busy)
  `SITOA_ASSERT(a_char_legal, clk, rst, m_tvalid |-> char_ok)

endmodule

`default_nettype wire
